[design/lbth_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbth_pkg
// Shared types, constants and index helpers of the letter pair/triple
// histogram.
// ----------------------------------------------------------------------------
package lbth_pkg;

	// counter width of both tables (8..64)
	localparam int unsigned COUNT_BITS = 32;
	localparam int unsigned OUT_BITS   = 32;

	localparam int unsigned ALPHA      = 26;
	localparam int unsigned PAIR_DEPTH = ALPHA * ALPHA;
	localparam int unsigned TRI_DEPTH  = ALPHA * ALPHA * ALPHA;
	localparam int unsigned PAIR_AW    = $clog2(PAIR_DEPTH);
	localparam int unsigned TRI_AW     = $clog2(TRI_DEPTH);
	localparam int unsigned LTR_W      = 5;

	localparam logic [7:0] CHAR_LO = 8'h61; // 'a'
	localparam logic [7:0] CHAR_HI = 8'h7A; // 'z'

	// result queue depth
	localparam int unsigned OUT_DEPTH = 3;
	localparam int unsigned OQ_PW     = $clog2(OUT_DEPTH);
	localparam int unsigned OQ_CW     = $clog2(OUT_DEPTH + 1);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		FN_BYTE    = 2'd0,
		FN_EOD     = 2'd1,
		FN_RD_PAIR = 2'd2,
		FN_RD_TRI  = 2'd3
	} func_t;

	// table request issued at acceptance
	typedef struct packed {
		logic               pair_inc;
		logic [PAIR_AW-1:0] pair_addr;
		logic               tri_inc;
		logic [TRI_AW-1:0]  tri_addr;
	} tbl_req_t;

	function automatic logic [PAIR_AW-1:0] pair_index(
		input logic [LTR_W-1:0] hi,
		input logic [LTR_W-1:0] lo
	);
		return PAIR_AW'(hi) * PAIR_AW'(ALPHA) + PAIR_AW'(lo);
	endfunction

	function automatic logic [TRI_AW-1:0] tri_index(
		input logic [LTR_W-1:0] hi,
		input logic [LTR_W-1:0] mid,
		input logic [LTR_W-1:0] lo
	);
		return TRI_AW'(pair_index(hi, mid)) * TRI_AW'(ALPHA) + TRI_AW'(lo);
	endfunction

	// clip a counter to the 32-bit result field
	function automatic logic [OUT_BITS-1:0] clip_out(input logic [COUNT_BITS-1:0] v);
		logic [COUNT_BITS+OUT_BITS-1:0] w;
		w = {{OUT_BITS{1'b0}}, v};
		if (w[COUNT_BITS+OUT_BITS-1:OUT_BITS] != '0)
			return '1;
		return w[OUT_BITS-1:0];
	endfunction

endpackage

[design/lbth_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbth_ram
// Generic single-write, single-read RAM with registered read data.
// A read at the address being written returns the old word.
// ----------------------------------------------------------------------------
module lbth_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/lbth_rmw.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbth_rmw
// Pair and triple counter tables: read at acceptance, saturating increment
// and write-back in the next cycle, forwarding from the previous write.
// Sweeps both tables to zero after reset.
// ----------------------------------------------------------------------------
module lbth_rmw
	import lbth_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  tbl_req_t              req,
	output logic [COUNT_BITS-1:0] pair_val,
	output logic [COUNT_BITS-1:0] tri_val,
	output logic                  busy
);

	// clear sweep
	logic              clearing_q;
	logic [TRI_AW-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == TRI_AW'(TRI_DEPTH - 1))
				clearing_q <= 1'b0;
			clr_q <= clr_q + 1'b1;
		end
	end

	assign busy = clearing_q;

	// stage 1: request in flight, stage 2: last write
	logic               p_inc_s1, t_inc_s1;
	logic [PAIR_AW-1:0] p_addr_s1;
	logic [TRI_AW-1:0]  t_addr_s1;
	logic               p_wr_s2, t_wr_s2;
	logic [PAIR_AW-1:0] p_addr_s2;
	logic [TRI_AW-1:0]  t_addr_s2;
	logic [COUNT_BITS-1:0] p_data_s2, t_data_s2;

	logic [COUNT_BITS-1:0] p_rdata, t_rdata;
	logic [COUNT_BITS-1:0] p_next, t_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_inc_s1 <= 1'b0;
			t_inc_s1 <= 1'b0;
			p_wr_s2  <= 1'b0;
			t_wr_s2  <= 1'b0;
		end else begin
			p_inc_s1 <= req.pair_inc;
			t_inc_s1 <= req.tri_inc;
			p_wr_s2  <= p_inc_s1;
			t_wr_s2  <= t_inc_s1;
		end
	end

	always_ff @(posedge clk) begin
		p_addr_s1 <= req.pair_addr;
		t_addr_s1 <= req.tri_addr;
		p_addr_s2 <= p_addr_s1;
		t_addr_s2 <= t_addr_s1;
		p_data_s2 <= p_next;
		t_data_s2 <= t_next;
	end

	// the RAM still holds the old word for a write made at the read edge
	assign pair_val = (p_wr_s2 && p_addr_s2 == p_addr_s1) ? p_data_s2 : p_rdata;
	assign tri_val  = (t_wr_s2 && t_addr_s2 == t_addr_s1) ? t_data_s2 : t_rdata;

	assign p_next = (pair_val == COUNT_MAX) ? pair_val : pair_val + 1'b1;
	assign t_next = (tri_val == COUNT_MAX) ? tri_val : tri_val + 1'b1;

	logic                  p_we, t_we;
	logic [PAIR_AW-1:0]    p_waddr;
	logic [TRI_AW-1:0]     t_waddr;
	logic [COUNT_BITS-1:0] p_wdata, t_wdata;

	always_comb begin
		if (clearing_q) begin
			p_we    = (clr_q < TRI_AW'(PAIR_DEPTH));
			p_waddr = clr_q[PAIR_AW-1:0];
			p_wdata = '0;
			t_we    = 1'b1;
			t_waddr = clr_q;
			t_wdata = '0;
		end else begin
			p_we    = p_inc_s1;
			p_waddr = p_addr_s1;
			p_wdata = p_next;
			t_we    = t_inc_s1;
			t_waddr = t_addr_s1;
			t_wdata = t_next;
		end
	end

	lbth_ram #(.WIDTH(COUNT_BITS), .DEPTH(PAIR_DEPTH)) u_pair_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (p_waddr),
		.wdata (p_wdata),
		.raddr (req.pair_addr),
		.rdata (p_rdata)
	);

	lbth_ram #(.WIDTH(COUNT_BITS), .DEPTH(TRI_DEPTH)) u_tri_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (req.tri_addr),
		.rdata (t_rdata)
	);

	// no counter update may be issued during the sweep
	a_no_inc_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing_q |-> !(req.pair_inc || req.tri_inc))
		else $error("table update issued while clearing");

endmodule

[design/lbth_outq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbth_outq
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module lbth_outq
	import lbth_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [OUT_BITS-1:0] push_data,
	output logic [OQ_CW-1:0]    cnt,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_BITS-1:0] count_value
);

	logic [OUT_BITS-1:0] mem_q [OUT_DEPTH];
	logic [OQ_PW-1:0]    wptr_q, rptr_q;
	logic [OQ_CW-1:0]    cnt_q;
	logic                pop;

	assign out_valid   = (cnt_q != '0);
	assign count_value = mem_q[rptr_q];
	assign pop         = out_valid && out_ready;
	assign cnt         = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == OQ_PW'(OUT_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == OQ_PW'(OUT_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_data;
	end

	// credit check upstream must keep the queue from overflowing
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < OQ_CW'(OUT_DEPTH)))
		else $error("result queue overflow");

endmodule

[design/letter_bigram_trigram_histogram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_bigram_trigram_histogram
// Counts adjacent lowercase letter pairs (26x26) and triples (26x26x26)
// over a text byte stream; read words return one saturating counter.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while in_ready is high, any mix of
// bytes, ends and reads; in_ready drops when the result queue has no
// free slot. A read word's count comes from the table read stage into
// the result queue that drives count_value. Counter updates are a
// read-modify-write; forwarding from the last write keeps same-entry
// updates back to back. Reset: history is cleared at once; then both
// tables are swept to zero, one entry per cycle, with in_ready low.
// ----------------------------------------------------------------------------
module letter_bigram_trigram_histogram
	import lbth_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          func,
	input  logic [7:0]          text_byte,
	input  logic [LTR_W-1:0]    first_letter,
	input  logic [LTR_W-1:0]    second_letter,
	input  logic [LTR_W-1:0]    third_letter,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_BITS-1:0] count_value
);

	func_t fn;
	logic  accept;
	assign fn     = func_t'(func);
	assign accept = in_valid && in_ready;

	// history of the last two bytes
	logic [LTR_W-1:0] prev_a_q, prev_b_q;
	logic             prev_va_q, prev_vb_q;

	logic             is_letter;
	logic [7:0]       byte_off;
	logic [LTR_W-1:0] cur;

	assign is_letter = (text_byte >= CHAR_LO) && (text_byte <= CHAR_HI);
	assign byte_off  = text_byte - CHAR_LO;
	assign cur       = is_letter ? byte_off[LTR_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q  <= '0;
			prev_va_q <= 1'b0;
			prev_b_q  <= '0;
			prev_vb_q <= 1'b0;
		end else if (accept) begin
			case (fn)
				FN_BYTE: begin
					prev_b_q  <= prev_a_q;
					prev_vb_q <= prev_va_q;
					prev_a_q  <= cur;
					prev_va_q <= is_letter;
				end
				FN_EOD: begin
					prev_a_q  <= '0;
					prev_va_q <= 1'b0;
					prev_b_q  <= '0;
					prev_vb_q <= 1'b0;
				end
				default: begin
					// reads leave the history alone
				end
			endcase
		end
	end

	// table addresses: history for bytes, query letters for reads
	logic     is_byte, is_read;
	tbl_req_t req;

	assign is_byte = (fn == FN_BYTE);
	assign is_read = (fn == FN_RD_PAIR) || (fn == FN_RD_TRI);

	always_comb begin
		req.pair_inc = accept && is_byte && is_letter && prev_va_q;
		req.tri_inc  = accept && is_byte && is_letter && prev_va_q && prev_vb_q;
		if (is_byte) begin
			req.pair_addr = pair_index(prev_a_q, cur);
			req.tri_addr  = tri_index(prev_b_q, prev_a_q, cur);
		end else begin
			req.pair_addr = pair_index(first_letter, second_letter);
			req.tri_addr  = tri_index(first_letter, second_letter, third_letter);
		end
	end

	// out-of-range query letters give a zero count
	logic bad_pair, bad_tri;
	assign bad_pair = (first_letter >= LTR_W'(ALPHA)) || (second_letter >= LTR_W'(ALPHA));
	assign bad_tri  = bad_pair || (third_letter >= LTR_W'(ALPHA));

	logic                  busy;
	logic [COUNT_BITS-1:0] pair_val, tri_val;

	lbth_rmw u_rmw (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.pair_val (pair_val),
		.tri_val  (tri_val),
		.busy     (busy)
	);

	// read word in the table read stage
	logic rd_s1, sel_tri_s1, zero_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rd_s1 <= 1'b0;
		else
			rd_s1 <= accept && is_read;
	end

	always_ff @(posedge clk) begin
		sel_tri_s1 <= (fn == FN_RD_TRI);
		zero_s1    <= (fn == FN_RD_TRI) ? bad_tri : bad_pair;
	end

	logic [OUT_BITS-1:0] rd_word;
	assign rd_word = zero_s1 ? '0 : clip_out(sel_tri_s1 ? tri_val : pair_val);

	logic [OQ_CW-1:0] oq_cnt;

	lbth_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (rd_s1),
		.push_data   (rd_word),
		.cnt         (oq_cnt),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.count_value (count_value)
	);

	// credit: queued words plus the one in flight must leave a free slot,
	// so in_ready does not depend on out_ready
	logic [OQ_CW:0] used;
	assign used     = {1'b0, oq_cnt} + (OQ_CW + 1)'(rd_s1);
	assign in_ready = !busy && (used < (OQ_CW + 1)'(OUT_DEPTH));

	a_read_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_read) |=> rd_s1)
		else $error("accepted read word not tracked");

	a_quiet_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!out_valid && !rd_s1))
		else $error("result pending during table clear");

endmodule

[dv/letter_bigram_trigram_histogram_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_bigram_trigram_histogram_tb
// Self-checking bench for the letter pair/triple histogram: a queue-fed
// driver and a monitor, with a cycle-level copy of both count tables that
// predicts the value of every read word.
// ----------------------------------------------------------------------------
module letter_bigram_trigram_histogram_tb
	import lbth_pkg::*;
();

	// one input word as queued for the driver
	typedef struct {
		func_t          fn;
		logic [7:0]     ch;
		logic [LTR_W-1:0] l0;
		logic [LTR_W-1:0] l1;
		logic [LTR_W-1:0] l2;
	} text_word_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [1:0]          func = FN_BYTE;
	logic [7:0]          text_byte = 8'h00;
	logic [LTR_W-1:0]    first_letter = '0;
	logic [LTR_W-1:0]    second_letter = '0;
	logic [LTR_W-1:0]    third_letter = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [OUT_BITS-1:0] count_value;

	letter_bigram_trigram_histogram u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.text_byte    (text_byte),
		.first_letter (first_letter),
		.second_letter(second_letter),
		.third_letter (third_letter),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.count_value  (count_value)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// stimulus and scoreboard storage
	text_word_t          pending_words[$];
	text_word_t          next_word;
	logic [OUT_BITS-1:0] expected_counts[$];
	int unsigned         queued_cnt = 0;
	int unsigned         taken_cnt = 0;
	int unsigned         errors = 0;
	logic                in_taken = 1'b0;
	logic                hold_out = 1'b0;
	logic                calm;

	// window with no random idling on either side
	assign calm = (taken_cnt >= 250) && (taken_cnt < 380);

	// predictor state: two-byte letter history and both count tables
	logic [LTR_W-1:0]      last_ltr = '0;
	logic                  last_ok = 1'b0;
	logic [LTR_W-1:0]      prior_ltr = '0;
	logic                  prior_ok = 1'b0;
	logic [COUNT_BITS-1:0] pair_tbl[PAIR_DEPTH];
	logic [COUNT_BITS-1:0] tri_tbl[TRI_DEPTH];

	initial begin
		foreach (pair_tbl[i]) pair_tbl[i] = '0;
		foreach (tri_tbl[i]) tri_tbl[i] = '0;
	end

	// clip a table entry to the 32-bit count field
	function automatic logic [OUT_BITS-1:0] to_count(input logic [COUNT_BITS-1:0] v);
		longint unsigned w;
		w = longint'(v);
		if (w > 64'h0000_0000_FFFF_FFFF)
			return '1;
		return w[OUT_BITS-1:0];
	endfunction

	// apply one accepted word to the predicted state
	task automatic update_histogram(input text_word_t w);
		logic        hit;
		int unsigned cur;
		int unsigned idx;
		case (w.fn)
			FN_BYTE: begin
				hit = (w.ch >= CHAR_LO) && (w.ch <= CHAR_HI);
				cur = hit ? int'(w.ch - CHAR_LO) : 0;
				if (hit && last_ok) begin
					idx = last_ltr * ALPHA + cur;
					if (pair_tbl[idx] != COUNT_MAX)
						pair_tbl[idx] = pair_tbl[idx] + 1'b1;
				end
				// a triple needs both history bytes to be letters
				if (hit && last_ok && prior_ok) begin
					idx = (prior_ltr * ALPHA + last_ltr) * ALPHA + cur;
					if (tri_tbl[idx] != COUNT_MAX)
						tri_tbl[idx] = tri_tbl[idx] + 1'b1;
				end
				prior_ltr = last_ltr;
				prior_ok  = last_ok;
				last_ltr  = LTR_W'(cur);
				last_ok   = hit;
			end
			FN_EOD: begin
				// new document: history drops, tables stay
				last_ltr  = '0;
				last_ok   = 1'b0;
				prior_ltr = '0;
				prior_ok  = 1'b0;
			end
			FN_RD_PAIR: begin
				if (w.l0 >= ALPHA || w.l1 >= ALPHA)
					expected_counts.push_back('0);
				else
					expected_counts.push_back(to_count(pair_tbl[w.l0 * ALPHA + w.l1]));
			end
			default: begin
				if (w.l0 >= ALPHA || w.l1 >= ALPHA || w.l2 >= ALPHA)
					expected_counts.push_back('0);
				else
					expected_counts.push_back(
						to_count(tri_tbl[(w.l0 * ALPHA + w.l1) * ALPHA + w.l2]));
			end
		endcase
	endtask

	task automatic note_mismatch(input string msg);
		errors++;
		if (errors <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// --- queue fillers ------------------------------------------------------
	// Fields a word does not use get random values so every bit toggles.
	task automatic push_word(input func_t fn, input logic [7:0] ch,
		input logic [LTR_W-1:0] a, input logic [LTR_W-1:0] b,
		input logic [LTR_W-1:0] c);
		text_word_t w;
		w.fn = fn;
		w.ch = ch;
		w.l0 = a;
		w.l1 = b;
		w.l2 = c;
		pending_words.push_back(w);
		queued_cnt++;
	endtask

	task automatic push_byte(input logic [7:0] ch);
		push_word(FN_BYTE, ch, LTR_W'($urandom_range(31)), LTR_W'($urandom_range(31)),
			LTR_W'($urandom_range(31)));
	endtask

	task automatic push_end();
		push_word(FN_EOD, 8'($urandom_range(255)), LTR_W'($urandom_range(31)),
			LTR_W'($urandom_range(31)), LTR_W'($urandom_range(31)));
	endtask

	task automatic push_read(input func_t fn, input logic [LTR_W-1:0] a,
		input logic [LTR_W-1:0] b, input logic [LTR_W-1:0] c);
		push_word(fn, 8'($urandom_range(255)), a, b, c);
	endtask

	// letters lean on a-e so pairs and triples repeat and counts grow
	function automatic logic [LTR_W-1:0] pick_ltr();
		if ($urandom_range(99) < 70)
			return LTR_W'($urandom_range(4));
		return LTR_W'($urandom_range(25));
	endfunction

	// query index, now and then past 'z'
	function automatic logic [LTR_W-1:0] query_ltr();
		if ($urandom_range(99) < 8)
			return LTR_W'($urandom_range(31));
		return pick_ltr();
	endfunction

	task automatic fill_random(input int unsigned n);
		int unsigned stop_at;
		int unsigned r;
		int unsigned len;
		stop_at = queued_cnt + n;
		while (queued_cnt < stop_at) begin
			r = $urandom_range(99);
			if (r < 45) begin
				// a word of letters, then a separator
				len = $urandom_range(7, 1);
				repeat (len) push_byte(CHAR_LO + 8'(pick_ltr()));
				case ($urandom_range(3))
					0: push_byte(8'h20);
					1: push_byte(8'h41 + 8'($urandom_range(25)));
					2: push_byte($urandom_range(1) ? 8'h60 : 8'h7B);
					default: push_byte(8'($urandom_range(255)));
				endcase
			end else if (r < 52) begin
				push_end();
			end else if (r < 58) begin
				repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
			end else if (r < 88) begin
				push_read(FN_RD_PAIR, query_ltr(), query_ltr(),
					LTR_W'($urandom_range(31)));
			end else begin
				push_read(FN_RD_TRI, query_ltr(), query_ltr(), query_ltr());
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || taken_cnt != queued_cnt ||
			expected_counts.size() != 0)
			@(posedge clk);
	endtask

	// --- driver -------------------------------------------------------------
	// Changes inputs on the falling edge; a word is held until taken.
	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (arst_n && pending_words.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
				next_word = pending_words.pop_front();
				func          <= next_word.fn;
				text_byte     <= next_word.ch;
				first_letter  <= next_word.l0;
				second_letter <= next_word.l1;
				third_letter  <= next_word.l2;
				in_valid      <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input side: every accepted word goes through the predictor
	always @(posedge clk) begin
		text_word_t w;
		in_taken <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			w.fn = func_t'(func);
			w.ch = text_byte;
			w.l0 = first_letter;
			w.l1 = second_letter;
			w.l2 = third_letter;
			update_histogram(w);
			taken_cnt <= taken_cnt + 1;
		end
	end

	// --- receiver -----------------------------------------------------------
	always @(negedge clk) begin
		if (hold_out)
			out_ready <= 1'b0;
		else
			out_ready <= calm || ($urandom_range(99) >= 19);
	end

	// long back-pressure: outputs stall while reads keep arriving, so the
	// result queue fills and in_ready must drop
	initial begin
		wait (taken_cnt >= 560);
		@(negedge clk);
		hold_out <= 1'b1;
		repeat (120) @(negedge clk);
		hold_out <= 1'b0;
	end

	// --- monitor ------------------------------------------------------------
	always @(posedge clk) begin
		logic [OUT_BITS-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_counts.size() == 0) begin
				note_mismatch($sformatf("unexpected count word 0x%08h", count_value));
			end else begin
				want = expected_counts.pop_front();
				if (count_value !== want)
					note_mismatch($sformatf("count_value expected 0x%08h got 0x%08h",
						want, count_value));
			end
		end
	end

	// --- stimulus sequence --------------------------------------------------
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fresh table, repeated pairs/triples, letter bounds,
		// non-letters at both ends of the byte range, a document break,
		// and reads with indexes past 'z'
		push_read(FN_RD_PAIR, 5'd0, 5'd0, 5'd0);
		push_byte("a"); push_byte("b"); push_byte("c");
		push_byte("a"); push_byte("b"); push_byte("c");
		push_byte(8'h60); push_byte("z"); push_byte("z");
		push_byte(8'h7B); push_byte(8'hFF); push_byte(8'h00);
		push_byte("a"); push_byte("b"); push_end(); push_byte("c");
		push_read(FN_RD_PAIR, 5'd0, 5'd1, 5'd0);
		push_read(FN_RD_TRI, 5'd0, 5'd1, 5'd2);
		push_read(FN_RD_PAIR, 5'd25, 5'd25, 5'd31);
		push_read(FN_RD_PAIR, 5'd1, 5'd2, 5'd0);
		push_read(FN_RD_PAIR, 5'd26, 5'd0, 5'd0);
		push_read(FN_RD_TRI, 5'd0, 5'd1, 5'd31);
		push_read(FN_RD_TRI, 5'd25, 5'd25, 5'd25);
		wait_drained();

		// random text in two runs; the sender sits idle between them
		// until every count has come back
		fill_random(450);
		wait_drained();
		fill_random(400);
		wait_drained();

		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog: covers the reset sweep plus the whole run, with margin
	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
